// ===== rtl/b64le_pkg.sv =====
// Shared types and constants for the base64 line encoder.
// Depends on nothing; every module of the block imports it.
package b64le_pkg;

	localparam logic [7:0] LINE_LEN_RESET  = 8'd72;
	localparam logic [7:0] PAD_CHAR        = 8'd61;
	localparam int         QUEUE_DEPTH_DEF = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       line_end;
		logic       stream_end;
	} char_item_t;

	// One group of three bytes, zero-filled, with the number of '=' pads.
	typedef struct packed {
		logic [23:0] triple;
		logic [1:0]  pad_count;
		logic        fin;
	} group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} group_beat_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		c = 8'd0;
		case (v) inside
			[6'd0:6'd25]:  c = 8'd65 + {2'b00, v};
			[6'd26:6'd51]: c = 8'd71 + {2'b00, v};
			[6'd52:6'd61]: c = {2'b00, v} - 8'd4;
			6'd62:         c = 8'd43;
			default:       c = 8'd47;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/b64le_front.sv =====
// Front end: accepts bytes, collects groups of three, classifies the final group.
// Depends on b64le_pkg.
module b64le_front import b64le_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  byte_item_t  byte_item,
	output group_beat_t grp_push
);

	logic [1:0]  pos_q;
	logic [15:0] held_q;

	always_comb begin
		grp_push = '0;
		if (accept) begin
			if (pos_q == 2'd2) begin
				grp_push.valid         = 1'b1;
				grp_push.grp.triple    = {held_q, byte_item.data_byte};
				grp_push.grp.pad_count = 2'd0;
				grp_push.grp.fin       = byte_item.final_byte;
			end else if (byte_item.final_byte) begin
				grp_push.valid = 1'b1;
				grp_push.grp.fin = 1'b1;
				if (pos_q == 2'd1) begin
					grp_push.grp.triple    = {held_q[7:0], byte_item.data_byte, 8'h00};
					grp_push.grp.pad_count = 2'd1;
				end else begin
					grp_push.grp.triple    = {byte_item.data_byte, 16'h0000};
					grp_push.grp.pad_count = 2'd2;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			held_q <= 16'h0000;
		end else if (accept) begin
			if (grp_push.valid) begin
				pos_q  <= 2'd0;
				held_q <= 16'h0000;
			end else if (pos_q == 2'd1) begin
				pos_q  <= 2'd2;
				held_q <= {held_q[7:0], byte_item.data_byte};
			end else begin
				// position 3 cannot arise; treat it as an empty group
				pos_q  <= 2'd1;
				held_q <= {8'h00, byte_item.data_byte};
			end
		end
	end

endmodule

// ===== rtl/b64le_queue.sv =====
// Short group queue between front and back end.
// Depends on b64le_pkg.
module b64le_queue import b64le_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  group_beat_t grp_push,
	input  logic        take,
	output group_beat_t head,
	output logic        full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	group_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_take;

	assign full      = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.grp   = mem[rd_ptr_q];
	assign do_push   = grp_push.valid && !full;
	assign do_take   = take && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= grp_push.grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_take) begin
				count_q <= count_q + 1'b1;
			end else if (do_take && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/b64le_back.sv =====
// Back end: emits four characters per group, tracks line columns, holds the
// output register. Depends on b64le_pkg.
module b64le_back import b64le_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	input  group_beat_t head,
	output logic        take,
	output char_item_t  char_item,
	output logic        empty,
	input  logic        pop
);

	logic [7:0] len_q;
	logic [7:0] col_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	char_item_t char_q;

	logic       fire;
	logic [5:0] sextet;
	logic       is_pad;
	logic [8:0] next_col;
	logic       eol;
	logic       last;

	assign fire = head.valid && (!out_valid_q || pop);
	assign take = fire && (idx_q == 2'd3);

	always_comb begin
		case (idx_q)
			2'd0:    sextet = head.grp.triple[23:18];
			2'd1:    sextet = head.grp.triple[17:12];
			2'd2:    sextet = head.grp.triple[11:6];
			default: sextet = head.grp.triple[5:0];
		endcase
		is_pad   = ((idx_q == 2'd3) && (head.grp.pad_count != 2'd0)) ||
		           ((idx_q == 2'd2) && (head.grp.pad_count == 2'd2));
		next_col = {1'b0, col_q} + 9'd1;
		eol      = (next_col >= {1'b0, len_q});
		last     = head.grp.fin && (idx_q == 2'd3);
	end

	assign char_item = char_q;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q.out_char   <= is_pad ? PAD_CHAR : sextet_char(sextet);
			char_q.line_end   <= eol;
			char_q.stream_end <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LINE_LEN_RESET;
			col_q       <= 8'd0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_data;
			end
			if (fire) begin
				idx_q       <= idx_q + 2'd1;
				out_valid_q <= 1'b1;
				// restart the line at line end or at end of stream
				col_q       <= (eol || last) ? 8'd0 : next_col[7:0];
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/base64_line_encoder_top.sv =====
// Top level of the base64 line encoder: front end, group queue, back end.
// Depends on b64le_pkg, b64le_front, b64le_queue, b64le_back.
//
//   channel   direction  handshake            beat
//   bytes     in         push / full          byte_item (data_byte, final_byte)
//   chars     out        pop / empty          char_item (out_char, line_end, stream_end)
//   config    in         cfg_we               cfg_data (characters per line)
//
// A byte is taken each cycle while the group queue has room; the back end sends
// one character per cycle while pop is held, four per group, so the sustained
// byte rate is set by the single-character output register.
// A stalled pop holds the output register; the queue then fills and raises full.
// Reset clears control state and loads line length 72; there is no clearing pass.
module base64_line_encoder_top import b64le_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  byte_item_t byte_item,
	output logic       empty,
	input  logic       pop,
	output char_item_t char_item,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data
);

	group_beat_t grp_push;
	group_beat_t head;
	logic        take;

	b64le_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (push && !full),
		.byte_item (byte_item),
		.grp_push  (grp_push)
	);

	b64le_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp_push (grp_push),
		.take     (take),
		.head     (head),
		.full     (full)
	);

	b64le_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.head      (head),
		.take      (take),
		.char_item (char_item),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== test/tb_base64_line_encoder_top.sv =====
// Self-checking testbench for base64_line_encoder_top: bytes go in through the queue-like input,
// and each character is checked against an in-bench base64 encoder with line and stream marks.
// Depends on b64le_pkg and the RTL of base64_line_encoder_top.
module tb_base64_line_encoder_top;
	timeunit 1ns;
	timeprecision 1ps;
	import b64le_pkg::*;

	localparam int    LIMIT_CYCLES  = 200000;
	localparam int    SETTLE_CYCLES = 10;
	localparam int    LONG_STALL    = 250;
	localparam string ALPHABET      =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       push     = 1'b0;
	logic       full;
	byte_item_t byte_item = '0;
	logic       empty;
	logic       pop      = 1'b0;
	char_item_t char_item;
	logic       cfg_we   = 1'b0;
	logic [7:0] cfg_data = '0;

	// encoder state mirrored by the bench
	logic [7:0]  line_len_model = LINE_LEN_RESET;
	logic [15:0] held_pair      = '0;
	logic [1:0]  group_fill     = '0;
	logic [7:0]  col_count      = '0;
	char_item_t  expected_chars[$];

	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	bit long_stall_req = 1'b0;
	int errors         = 0;
	int bytes_sent     = 0;
	int chars_checked  = 0;
	int line_ends_seen = 0;
	int streams_seen   = 0;
	int full_waits     = 0;
	int cfg_writes     = 0;
	int cycles         = 0;

	base64_line_encoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.byte_item (byte_item),
		.empty     (empty),
		.pop       (pop),
		.char_item (char_item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d characters outstanding", cycles,
				expected_chars.size());
			$display("tb_base64_line_encoder_top failed");
			$finish;
		end
	end

	function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
		return 8'(ALPHABET[v]);
	endfunction

	// Advance the column and queue one character with its line and stream marks.
	function automatic void emit_char(input logic [7:0] ch, input logic last);
		int         next_col;
		logic       eol;
		char_item_t item;
		next_col = int'(col_count) + 1;
		eol = (next_col >= int'(line_len_model));
		col_count = eol ? 8'd0 : 8'(next_col);
		item = '{out_char: ch, line_end: eol, stream_end: last};
		expected_chars.insert(expected_chars.size(), item);
	endfunction

	function automatic void encode_byte(input logic [7:0] d, input logic fin);
		logic [23:0] triple;
		if (group_fill == 2'd2) begin
			triple = {held_pair, d};
			emit_char(sextet_ascii(triple[23:18]), 1'b0);
			emit_char(sextet_ascii(triple[17:12]), 1'b0);
			emit_char(sextet_ascii(triple[11:6]), 1'b0);
			emit_char(sextet_ascii(triple[5:0]), fin);
		end else if (fin) begin
			if (group_fill == 2'd1) begin
				triple = {held_pair[7:0], d, 8'h00};
				emit_char(sextet_ascii(triple[23:18]), 1'b0);
				emit_char(sextet_ascii(triple[17:12]), 1'b0);
				emit_char(sextet_ascii(triple[11:6]), 1'b0);
				emit_char(PAD_CHAR, 1'b1);
			end else begin
				triple = {d, 16'h0000};
				emit_char(sextet_ascii(triple[23:18]), 1'b0);
				emit_char(sextet_ascii(triple[17:12]), 1'b0);
				emit_char(PAD_CHAR, 1'b0);
				emit_char(PAD_CHAR, 1'b1);
			end
		end else begin
			// hold the byte until the group is complete
			held_pair = (group_fill == 2'd1) ? {held_pair[7:0], d} : {8'h00, d};
			group_fill = (group_fill == 2'd1) ? 2'd2 : 2'd1;
			return;
		end
		held_pair = '0;
		group_fill = '0;
		if (fin)
			col_count = '0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, wanted %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Check every character beat against the oldest queued prediction.
	always @(posedge clk) begin
		char_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_chars.size() == 0) begin
				report_mismatch("unpredicted character", char_item.out_char, -1);
			end else begin
				want = expected_chars.pop_front();
				if (char_item.out_char !== want.out_char)
					report_mismatch("out_char", char_item.out_char, want.out_char);
				if (char_item.line_end !== want.line_end)
					report_mismatch("line_end", char_item.line_end, want.line_end);
				if (char_item.stream_end !== want.stream_end)
					report_mismatch("stream_end", char_item.stream_end, want.stream_end);
			end
			chars_checked++;
			if (char_item.line_end)
				line_ends_seen++;
			if (char_item.stream_end)
				streams_seen++;
		end
	end

	// Receiver: random pop, or a long hold-off counted here on request.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				stall_left = LONG_STALL;
				long_stall_req = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one byte, idling at random first; push stays high on return.
	task automatic send_byte(input logic [7:0] d, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			byte_item <= '{data_byte: 8'($urandom), final_byte: 1'($urandom)};
			@(posedge clk);
		end
		push <= 1'b1;
		byte_item <= '{data_byte: d, final_byte: fin};
		@(posedge clk);
		while (full) begin
			full_waits++;
			@(posedge clk);
		end
		encode_byte(d, fin);
		bytes_sent++;
	endtask

	// Drop push and wait until every predicted character has come out.
	task automatic drain_chars();
		push <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_line_len(input logic [7:0] v);
		drain_chars();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		line_len_model = v;
		cfg_writes++;
	endtask

	function automatic logic [7:0] pick_line_len();
		case ($urandom_range(6))
			0:       return 8'd1;
			1:       return 8'd255;
			2:       return 8'd72;
			3:       return 8'($urandom_range(2, 4));
			4:       return 8'd0;
			default: return 8'($urandom_range(1, 20));
		endcase
	endfunction

	// full group, two-byte tail (one pad), one-byte tail (two pads), exact group at the end
	task automatic test_padding();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h83, 1'b1);
	endtask

	task automatic test_line_limits();
		write_line_len(8'd1);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);
		write_line_len(8'd0);
		send_byte(8'h3C, 1'b1);
		// the last line is filled exactly, so both marks land on one character
		write_line_len(8'd4);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h24, 1'b1);
		write_line_len(8'd255);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
	endtask

	// Shorten the line below the running column between two groups.
	task automatic test_line_shortened();
		write_line_len(8'd72);
		for (int i = 0; i < 6; i++)
			send_byte(8'(i * 41 + 7), 1'b0);
		write_line_len(8'd5);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'h99, 1'b1);
	endtask

	// Hold pop off for a long stretch while bytes keep coming, then pause the sender.
	task automatic test_backpressure();
		write_line_len(8'd6);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_stall_req = 1'b1;
		for (int i = 0; i < 24; i++)
			send_byte(8'($urandom), i == 23);
		drain_chars();
	endtask

	task automatic random_phase(input int n_bytes, input int s_idle, input int r_idle);
		int target;
		int len;
		int cut;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			if ($urandom_range(3) == 0)
				write_line_len(pick_line_len());
			len = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			// now and then change the line length at a group boundary mid-stream
			cut = ($urandom_range(5) == 0 && len > 4) ? 3 : 0;
			for (int i = 0; i < len; i++) begin
				if (cut != 0 && i == cut)
					write_line_len(pick_line_len());
				send_byte(8'($urandom), i == len - 1);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 38;
		recv_idle_pct = 67;
		test_padding();
		test_line_limits();
		test_line_shortened();
		random_phase(18, 38, 67);
		random_phase(18, 67, 38);
		test_backpressure();
		random_phase(14, 0, 0);
		drain_chars();
		$display("encoded %0d bytes into %0d characters over %0d streams, %0d line ends",
			bytes_sent, chars_checked, streams_seen, line_ends_seen);
		$display("%0d line-length writes, input held off by full for %0d cycles",
			cfg_writes, full_waits);
		if (errors == 0) begin
			$display("tb_base64_line_encoder_top passed");
		end else begin
			$display("tb_base64_line_encoder_top failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/b64le_pkg.sv
rtl/b64le_front.sv
rtl/b64le_queue.sv
rtl/b64le_back.sv
rtl/base64_line_encoder_top.sv
test/tb_base64_line_encoder_top.sv
